FILE: sv/tap_tempo_estimator_defines.svh
// Assertion macros for the tap tempo estimator.
// Used by the top level; depends on nothing.
`ifndef TAP_TEMPO_ESTIMATOR_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define TTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tap tempo check failed");

// Next-cycle implication, disabled while reset is low
`define TTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tap tempo check failed");

`endif

FILE: sv/tte_pkg.sv
// Shared types, constants and helper functions of the tap tempo estimator.
// Used by tte_lane, tte_merge and tap_tempo_estimator; depends on nothing.
`timescale 1ns / 1ps

package tte_pkg;

    localparam int unsigned DataW       = 32;
    localparam int unsigned SumW        = 34;
    // dividend of the divide-by-three, padded to whole groups of digits
    localparam int unsigned Div3DigitsPerCycle = 6;
    localparam int unsigned Div3Cycles  = 3;
    localparam int unsigned Div3W       = 2 * Div3DigitsPerCycle * Div3Cycles;
    localparam int unsigned DivSteps    = DataW;
    localparam int unsigned CntW        = $clog2(DivSteps);
    localparam int unsigned RingDepth   = 4;

    localparam logic [DataW-1:0] TpmReset = 32'd60000000;

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIFF,
        L_TEST,
        L_DIV3,
        L_DIV,
        L_DONE
    } t_lane_state;

    // what one lane reports to the merging stage
    typedef struct packed {
        logic             done;
        logic             updated;
        logic [DataW-1:0] tempo;
        logic [DataW-1:0] period;
        logic [DataW-1:0] update_time;
    } t_lane_res;

    // one radix-4 digit of a divide by three: {quotient digit, remainder}
    function automatic logic [3:0] div3_digit(input logic [3:0] x);
        logic [1:0] q;
        logic [3:0] r;
        if (x >= 4'd9) begin
            q = 2'd3;
            r = x - 4'd9;
        end else if (x >= 4'd6) begin
            q = 2'd2;
            r = x - 4'd6;
        end else if (x >= 4'd3) begin
            q = 2'd1;
            r = x - 4'd3;
        end else begin
            q = 2'd0;
            r = x;
        end
        return {q, r[1:0]};
    endfunction

endpackage

FILE: sv/tte_lane.sv
// One channel lane: tap history, interval check, divide by three and tempo divider.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_lane import tte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_ack,
    input  logic [DataW-1:0] i_tap,
    input  logic [DataW-1:0] i_now,
    input  logic [DataW-1:0] i_tpm,
    output t_lane_res        o_res
);

    t_lane_state r_state;
    t_lane_state n_state;

    // taps in age order: entry 0 oldest, last entry newest
    logic [DataW-1:0] r_ring [RingDepth];
    logic [DataW-1:0] r_last_tap;
    logic [DataW-1:0] r_now;
    logic [DataW-1:0] r_tpm;
    logic [DataW-1:0] r_i0;
    logic [DataW-1:0] r_i1;
    logic [DataW-1:0] r_i2;
    logic [Div3W-1:0] r_sum;
    logic [Div3W-1:0] r_q3;
    logic [1:0]       r_rem3;
    logic [CntW-1:0]  r_cnt;
    logic [DataW-1:0] r_div_rem;
    logic [DataW-1:0] r_div_dvd;
    logic [DataW-1:0] r_divisor;
    logic             r_updated;
    logic [DataW-1:0] r_tempo;
    logic [DataW-1:0] r_period;
    logic [DataW-1:0] r_upd_time;

    logic             new_tap;
    logic             agree;
    logic [SumW-1:0]  sum3;
    logic [Div3W-1:0] n_q3;
    logic [1:0]       n_rem3;
    logic [DataW:0]   div_shift;
    logic             div_fit;
    logic [DataW-1:0] n_div_rem;
    logic             done;

    assign new_tap = (i_tap != r_last_tap);

    // tolerance test in 35 bits: 4*i1 < 5*i0, 4*i2 < 5*i0, 4*i0 < 5*i2
    always_comb begin
        logic [DataW+2:0] x4_0;
        logic [DataW+2:0] x4_1;
        logic [DataW+2:0] x4_2;
        logic [DataW+2:0] x5_0;
        logic [DataW+2:0] x5_2;
        x4_0  = {1'b0, r_i0, 2'b00};
        x4_1  = {1'b0, r_i1, 2'b00};
        x4_2  = {1'b0, r_i2, 2'b00};
        x5_0  = x4_0 + {3'b000, r_i0};
        x5_2  = x4_2 + {3'b000, r_i2};
        agree = (x4_1 < x5_0) && (x4_2 < x5_0) && (x4_0 < x5_2);
        sum3  = {2'b00, r_i0} + {2'b00, r_i1} + {2'b00, r_i2};
    end

    // divide by three, several radix-4 digits per cycle
    always_comb begin
        logic [1:0] rem;
        logic [3:0] dig;
        logic [Div3W-1:0] q;
        rem = r_rem3;
        q   = r_q3;
        for (int k = 0; k < Div3DigitsPerCycle; k++) begin
            dig = div3_digit({rem, r_sum[Div3W-1-2*k -: 2]});
            q   = {q[Div3W-3:0], dig[3:2]};
            rem = dig[1:0];
        end
        n_q3   = q;
        n_rem3 = rem;
    end

    // one restoring step of the tempo divider
    always_comb begin
        div_shift = {r_div_rem, r_div_dvd[DataW-1]};
        div_fit   = (div_shift >= {1'b0, r_divisor});
        if (div_fit) begin
            n_div_rem = div_shift[DataW-1:0] - r_divisor;
        end else begin
            n_div_rem = div_shift[DataW-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = new_tap ? L_DIFF : L_DONE;
                end
            end
            L_DIFF: n_state = L_TEST;
            L_TEST: n_state = agree ? L_DIV3 : L_DONE;
            L_DIV3: begin
                if (r_cnt == CntW'(Div3Cycles - 1)) begin
                    n_state = L_DIV;
                end
            end
            L_DIV: begin
                if (r_cnt == CntW'(DivSteps - 1)) begin
                    n_state = L_DONE;
                end
            end
            L_DONE: begin
                if (i_ack) begin
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        done = 1'b0;
        case (r_state)
            L_DONE:  done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    assign o_res.done        = done;
    assign o_res.updated     = r_updated;
    assign o_res.tempo       = r_tempo;
    assign o_res.period      = r_period;
    assign o_res.update_time = r_upd_time;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= L_IDLE;
            r_last_tap <= '0;
            r_tempo    <= '0;
            r_period   <= '0;
            r_upd_time <= '0;
            r_updated  <= 1'b0;
            for (int k = 0; k < RingDepth; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                L_IDLE: begin
                    // take a new tap into the history
                    if (i_start) begin
                        r_updated <= 1'b0;
                        if (new_tap) begin
                            for (int k = 0; k < RingDepth - 1; k++) begin
                                r_ring[k] <= r_ring[k+1];
                            end
                            r_ring[RingDepth-1] <= i_tap;
                            r_last_tap          <= i_tap;
                        end
                    end
                end
                L_DIV3: begin
                    if (r_cnt == CntW'(Div3Cycles - 1)) begin
                        r_period <= n_q3[DataW-1:0];
                    end
                end
                L_DIV: begin
                    // publish the estimate
                    if (r_cnt == CntW'(DivSteps - 1)) begin
                        r_tempo    <= {r_div_dvd[DataW-2:0], div_fit};
                        r_upd_time <= r_now;
                        r_updated  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_now <= i_now;
                r_tpm <= i_tpm;
            end
            L_DIFF: begin
                r_i0 <= r_ring[1] - r_ring[0];
                r_i1 <= r_ring[2] - r_ring[1];
                r_i2 <= r_ring[3] - r_ring[2];
            end
            L_TEST: begin
                r_sum  <= {{(Div3W - SumW){1'b0}}, sum3};
                r_q3   <= '0;
                r_rem3 <= '0;
                r_cnt  <= '0;
            end
            L_DIV3: begin
                r_sum  <= {r_sum[Div3W-1-2*Div3DigitsPerCycle:0],
                           {(2*Div3DigitsPerCycle){1'b0}}};
                r_q3   <= n_q3;
                r_rem3 <= n_rem3;
                if (r_cnt == CntW'(Div3Cycles - 1)) begin
                    // load the tempo divider
                    r_divisor <= n_q3[DataW-1:0];
                    r_div_dvd <= r_tpm;
                    r_div_rem <= '0;
                    r_cnt     <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            L_DIV: begin
                r_div_rem <= n_div_rem;
                r_div_dvd <= {r_div_dvd[DataW-2:0], div_fit};
                r_cnt     <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/tte_merge.sv
// Merging stage: picks the active source and holds the result register.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_merge import tte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_lane_res        i_res_a,
    input  t_lane_res        i_res_b,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output logic [DataW-1:0] o_tempo_a,
    output logic [DataW-1:0] o_period_a,
    output logic             o_updated_a,
    output logic [DataW-1:0] o_tempo_b,
    output logic [DataW-1:0] o_period_b,
    output logic             o_updated_b,
    output logic             o_active_source
);

    logic r_valid;
    logic r_source_sel;
    logic n_source_sel;

    // later update wins, a tie keeps the current source
    always_comb begin
        n_source_sel = r_source_sel;
        if (i_res_a.update_time > i_res_b.update_time) begin
            n_source_sel = 1'b0;
        end else if (i_res_b.update_time > i_res_a.update_time) begin
            n_source_sel = 1'b1;
        end
    end

    assign o_space         = !r_valid || i_ready;
    assign o_valid         = r_valid;
    assign o_active_source = r_source_sel;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_source_sel <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid      <= 1'b1;
                r_source_sel <= n_source_sel;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold the result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_tempo_a   <= i_res_a.tempo;
            o_period_a  <= i_res_a.period;
            o_updated_a <= i_res_a.updated;
            o_tempo_b   <= i_res_b.tempo;
            o_period_b  <= i_res_b.period;
            o_updated_b <= i_res_b.updated;
        end
    end

endmodule

FILE: sv/tap_tempo_estimator.sv
// Tap tempo estimator top level: register, two channel lanes and the merging stage.
// Depends on tte_pkg, tte_lane, tte_merge and tap_tempo_estimator_defines.svh.
`timescale 1ns / 1ps
`include "tap_tempo_estimator_defines.svh"

// Takes one request at a time. A request in which some channel's timestamp
// changed and its last three intervals agree yields a valid result after
// these steps in each lane: the interval computation, the tolerance test,
// the divide by three and the radix-2 tempo divider, then the load into the
// output register, which waits while that register holds a result not yet
// taken; both lanes run side by side and the slower one sets the time. A
// lane whose new tap fails the tolerance test skips both divisions, and a
// lane with no new tap goes straight to its done state. The next request is
// accepted in the cycle after the result has moved to the output register,
// even while that result still waits to be taken. ticks_per_minute resets to
// 60000000 and is written through i_cfg_wr_en / i_cfg_wr_data.

module tap_tempo_estimator import tte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [DataW-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [DataW-1:0] i_tap_time_a,
    input  logic [DataW-1:0] i_tap_time_b,
    input  logic [DataW-1:0] i_now_ticks,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DataW-1:0] o_tempo_a,
    output logic [DataW-1:0] o_period_a,
    output logic             o_updated_a,
    output logic [DataW-1:0] o_tempo_b,
    output logic [DataW-1:0] o_period_b,
    output logic             o_updated_b,
    output logic             o_active_source
);

    logic [DataW-1:0] r_tpm;
    logic             r_busy;
    logic             start;
    logic             load;
    logic             space;
    t_lane_res        res_a;
    t_lane_res        res_b;

    assign o_ready = !r_busy;
    assign start   = i_valid && !r_busy;
    assign load    = r_busy && res_a.done && res_b.done && space;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm <= TpmReset;
        end else if (i_cfg_wr_en) begin
            r_tpm <= i_cfg_wr_data;
        end
    end

    // hold busy from accept until the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start) begin
            r_busy <= 1'b1;
        end else if (load) begin
            r_busy <= 1'b0;
        end
    end

    tte_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ack   (load),
        .i_tap   (i_tap_time_a),
        .i_now   (i_now_ticks),
        .i_tpm   (r_tpm),
        .o_res   (res_a)
    );

    tte_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ack   (load),
        .i_tap   (i_tap_time_b),
        .i_now   (i_now_ticks),
        .i_tpm   (r_tpm),
        .o_res   (res_b)
    );

    tte_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_res_a         (res_a),
        .i_res_b         (res_b),
        .i_ready         (i_ready),
        .o_space         (space),
        .o_valid         (o_valid),
        .o_tempo_a       (o_tempo_a),
        .o_period_a      (o_period_a),
        .o_updated_a     (o_updated_a),
        .o_tempo_b       (o_tempo_b),
        .o_period_b      (o_period_b),
        .o_updated_b     (o_updated_b),
        .o_active_source (o_active_source)
    );

    // lanes sit idle whenever no request is in flight
    `TTE_ASSERT_NOW(a_idle_lanes, i_clk, i_rst_n, !r_busy, !res_a.done && !res_b.done)
    // a result is loaded only once both lanes have finished
    `TTE_ASSERT_NOW(a_load_done, i_clk, i_rst_n, load, res_a.done && res_b.done)
    // a loaded result shows up at the output in the next cycle
    `TTE_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, load, o_valid && !r_busy)

endmodule
